// ===== src/vslab_pkg.sv =====
// Shared types, codes and helpers of the voxel slab to ARGB converter.
package vslab_pkg;

    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPAND_VGA   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 4'd1;

    localparam logic [2:0] KIND_TOP     = 3'd0;
    localparam logic [2:0] KIND_LEN     = 3'd1;
    localparam logic [2:0] KIND_CULL    = 3'd2;
    localparam logic [2:0] KIND_COLOUR  = 3'd3;
    localparam logic [2:0] KIND_IGNORED = 3'd4;

    localparam logic [15:0] HEADER_BYTES = 16'd3;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [3:0] {
        PH_TOP    = 4'b0001,
        PH_LEN    = 4'b0010,
        PH_CULL   = 4'b0100,
        PH_COLOUR = 4'b1000
    } slab_phase_t;

    // Classification of one slab byte, handed from the parser to the output stage.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] hdr_value;
        logic       too_tall;
        logic       block_end;
        logic       is_colour;
    } parse_res_t;

    // Widen one palette component; VGA components keep 6 bits, repeat the top two.
    function automatic logic [7:0] widen(input logic [7:0] c, input logic vga);
        logic [7:0] w;
        w = vga ? {c[5:0], c[5:4]} : c;
        return w;
    endfunction

endpackage

// ===== src/vslab_palette.sv =====
// Palette RAM: one write port, one registered read port with range check.
module vslab_palette #(
    parameter int unsigned ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        we,
    input  logic [7:0]  waddr,
    input  logic [23:0] wdata,
    input  logic        re,
    input  logic [7:0]  raddr,
    output logic [23:0] rgb
);

    localparam int unsigned IDX_W = $clog2(ENTRIES);
    localparam logic [8:0]  LIMIT = 9'(ENTRIES);

    logic [23:0] mem [ENTRIES];
    logic [23:0] rdata_reg;
    logic        hit_reg;
    logic        w_in_range;
    logic        r_in_range;

    assign w_in_range = {1'b0, waddr} < LIMIT;
    assign r_in_range = {1'b0, raddr} < LIMIT;

    always_ff @(posedge aclk) begin
        if (we && w_in_range) begin
            mem[waddr[IDX_W-1:0]] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr[IDX_W-1:0]];
            hit_reg   <= r_in_range;
        end
    end

    // Out-of-range index reads as black
    assign rgb = hit_reg ? rdata_reg : 24'h0;

endmodule

// ===== src/vslab_parser.sv =====
// Slab header parser: block and slab bookkeeping, one byte per step.
module vslab_parser (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  logic [7:0]                          data_byte,
    input  logic                                cfg_we,
    input  logic [vslab_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vslab_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output vslab_pkg::parse_res_t               res
);

    vslab_pkg::slab_phase_t phase_reg, phase_next;
    logic [15:0] block_length_reg, block_length_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  colours_left_reg, colours_left_next;
    logic        failed_reg, failed_next;

    always_comb begin
        logic        failed_v;
        logic [15:0] bytes_dec;
        logic [8:0]  need;

        phase_next        = phase_reg;
        block_length_next = block_length_reg;
        bytes_left_next   = bytes_left_reg;
        colours_left_next = colours_left_reg;
        failed_next       = failed_reg;
        failed_v          = failed_reg;
        bytes_dec         = bytes_left_reg - 16'd1;
        need              = {1'b0, data_byte} + 9'd2;

        res.kind      = vslab_pkg::KIND_IGNORED;
        res.hdr_value = 8'd0;
        res.too_tall  = 1'b0;
        res.block_end = 1'b0;
        res.is_colour = 1'b0;

        if (cfg_we && cfg_index == vslab_pkg::CFG_BLOCK_LENGTH) begin
            block_length_next = cfg_wdata[15:0];
            bytes_left_next   = cfg_wdata[15:0];
            phase_next        = vslab_pkg::PH_TOP;
            colours_left_next = 8'd0;
            failed_next       = 1'b0;
        end else if (step) begin
            if (bytes_left_reg == 16'd0) begin
                // empty block: flag end and restart
                res.block_end     = 1'b1;
                bytes_left_next   = block_length_reg;
                phase_next        = vslab_pkg::PH_TOP;
                colours_left_next = 8'd0;
                failed_next       = 1'b0;
            end else begin
                if (!failed_reg) begin
                    unique case (phase_reg)
                        vslab_pkg::PH_TOP: begin
                            if (bytes_left_reg >= vslab_pkg::HEADER_BYTES) begin
                                res.kind      = vslab_pkg::KIND_TOP;
                                res.hdr_value = data_byte;
                                phase_next    = vslab_pkg::PH_LEN;
                            end
                        end
                        vslab_pkg::PH_LEN: begin
                            if ({7'd0, need} > bytes_left_reg) begin
                                failed_v = 1'b1;
                            end else begin
                                res.kind          = vslab_pkg::KIND_LEN;
                                res.hdr_value     = data_byte;
                                colours_left_next = data_byte;
                                phase_next        = vslab_pkg::PH_CULL;
                            end
                        end
                        vslab_pkg::PH_CULL: begin
                            res.kind      = vslab_pkg::KIND_CULL;
                            res.hdr_value = data_byte;
                            phase_next    = (colours_left_reg != 8'd0) ?
                                            vslab_pkg::PH_COLOUR : vslab_pkg::PH_TOP;
                        end
                        vslab_pkg::PH_COLOUR: begin
                            res.kind          = vslab_pkg::KIND_COLOUR;
                            res.is_colour     = 1'b1;
                            colours_left_next = colours_left_reg - 8'd1;
                            if (colours_left_reg == 8'd1) begin
                                phase_next = vslab_pkg::PH_TOP;
                            end
                        end
                        default: begin
                            phase_next = vslab_pkg::PH_TOP;
                        end
                    endcase
                end
                res.too_tall    = failed_v;
                failed_next     = failed_v;
                bytes_left_next = bytes_dec;
                if (bytes_dec == 16'd0) begin
                    res.block_end     = 1'b1;
                    bytes_left_next   = block_length_reg;
                    phase_next        = vslab_pkg::PH_TOP;
                    colours_left_next = 8'd0;
                    failed_next       = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= vslab_pkg::PH_TOP;
            block_length_reg <= 16'd0;
            bytes_left_reg   <= 16'd0;
            colours_left_reg <= 8'd0;
            failed_reg       <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            block_length_reg <= block_length_next;
            bytes_left_reg   <= bytes_left_next;
            colours_left_reg <= colours_left_next;
            failed_reg       <= failed_next;
        end
    end

endmodule

// ===== src/voxel_slab_to_argb_converter_core.sv =====
// Top level of the voxel slab to ARGB converter.
//
// Input channel (s_): one request per byte. s_tuser selects the operation:
// 0 loads palette entry entry_index with red/green/blue (no result), 1 feeds
// one slab byte (exactly one result). Output channel (m_): byte kind and the
// too-tall flag in m_tuser, the header byte or ARGB word in m_tdata, and
// m_tlast on the last byte of a block.
// A result is registered and is valid in the cycle after its slab byte is accepted.
// Throughput: one request per cycle; the palette RAM is read on the accept
// edge and its registered word is widened on the way out to m_tdata.
// When the receiver stalls, the output register holds its result and
// s_tready drops until m_tready rises; a result leaving frees the register
// for a new request in the same cycle.
// Configuration: cfg_we writes register cfg_index (0 expand_vga, 1
// block_length); writing block_length restarts the block. Write only idle.
// Reset (aresetn low, synchronous) clears the output valid, sets VGA
// expansion, block_length 0 and the slab parser to expect a top byte. The
// palette RAM is not cleared; load entries before using them.
module voxel_slab_to_argb_converter_core #(
    parameter int unsigned PALETTE_ENTRIES = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // slab byte / palette write requests
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [39:0]                      s_tdata,  // data_byte, entry_index, red_in, green_in, blue_in
    input  logic [0:0]                       s_tuser,  // operation
    // results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,  // out_value
    output logic [3:0]                       m_tuser,  // byte_kind, too_tall
    output logic                             m_tlast,  // block_end
    // configuration
    input  logic                             cfg_we,
    input  logic [vslab_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vslab_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic        accept;
    logic        accept_byte;
    logic        accept_pal;
    logic [23:0] pal_rgb;

    vslab_pkg::parse_res_t res;

    logic       expand_vga_reg, expand_vga_next;
    logic       m_valid_reg, m_valid_next;
    logic [2:0] kind_reg;
    logic [7:0] hdr_reg;
    logic       too_tall_reg;
    logic       last_reg;
    logic       colour_reg;

    // Output register frees up as its result leaves
    assign s_tready    = !m_valid_reg || m_tready;
    assign accept      = s_tvalid && s_tready;
    assign accept_byte = accept && s_tuser[0];
    assign accept_pal  = accept && !s_tuser[0];

    vslab_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (accept_byte),
        .data_byte (s_tdata[7:0]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .res       (res)
    );

    // Palette write and colour lookup share the accept edge; one request
    // is either, never both, so no forwarding is needed.
    vslab_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .aclk  (aclk),
        .we    (accept_pal),
        .waddr (s_tdata[15:8]),
        .wdata ({s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]}),
        .re    (accept_byte),
        .raddr (s_tdata[7:0]),
        .rgb   (pal_rgb)
    );

    always_comb begin
        expand_vga_next = expand_vga_reg;
        if (cfg_we && cfg_index == vslab_pkg::CFG_EXPAND_VGA) begin
            expand_vga_next = cfg_wdata[0];
        end
    end

    // Hold the result until taken; load a new one on each slab byte
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept_byte) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expand_vga_reg <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            expand_vga_reg <= expand_vga_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_byte) begin
            kind_reg     <= res.kind;
            hdr_reg      <= res.hdr_value;
            too_tall_reg <= res.too_tall;
            last_reg     <= res.block_end;
            colour_reg   <= res.is_colour;
        end
    end

    // Colour bytes become opaque ARGB; header bytes pass zero-extended, ignored bytes read as zero
    assign m_tdata  = colour_reg ?
                      {vslab_pkg::ALPHA_OPAQUE,
                       vslab_pkg::widen(pal_rgb[23:16], expand_vga_reg),
                       vslab_pkg::widen(pal_rgb[15:8], expand_vga_reg),
                       vslab_pkg::widen(pal_rgb[7:0], expand_vga_reg)} :
                      {24'd0, hdr_reg};
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {too_tall_reg, kind_reg};
    assign m_tlast  = last_reg;

endmodule
